// ----- rtl/core/hsv2rgb_pkg.sv -----
// Shared types and constants for the HSV to RGB pixel converter.
package hsv2rgb_pkg;

  localparam int unsigned HUE_SECTOR = 960;
  localparam int unsigned FRAC_DEN   = 255 * HUE_SECTOR;

  // Reciprocal factors for the constant divides.
  // hue / 960 = (hue >> 6) / 15 ~ ((hue >> 6) * 4370) >> 16, exact for 16-bit hue
  localparam int unsigned RECIP_15    = 4370;
  localparam int unsigned RECIP_15_SH = 16;
  // n / 6 = (n * 43) >> 8, exact for n < 128
  localparam int unsigned RECIP_6     = 43;
  localparam int unsigned RECIP_6_SH  = 8;
  // Estimates below are low by at most one and get a correction step.
  localparam int unsigned RECIP_DEN_SH = 32;
  localparam int unsigned RECIP_DEN    = 32'((64'd1 << RECIP_DEN_SH) / FRAC_DEN);
  localparam int unsigned RECIP_255    = 257;
  localparam int unsigned RECIP_255_SH = 16;

  localparam logic [2:0] SECTOR_RED_YEL = 3'd0;
  localparam logic [2:0] SECTOR_YEL_GRN = 3'd1;
  localparam logic [2:0] SECTOR_GRN_CYN = 3'd2;
  localparam logic [2:0] SECTOR_CYN_BLU = 3'd3;
  localparam logic [2:0] SECTOR_BLU_MAG = 3'd4;

  typedef struct packed {
    logic [15:0] hue;
    logic [7:0]  sat;
    logic [7:0]  val;
    logic [7:0]  alpha;
  } pix_t;

  typedef struct packed {
    logic [2:0] sector;
    logic [9:0] frac;
    logic [7:0] sat;
    logic [7:0] val;
    logic [7:0] alpha;
  } sect_t;

  typedef struct packed {
    logic [2:0]  sector;
    logic [7:0]  val;
    logic [7:0]  alpha;
    logic [25:0] yq;
    logic [25:0] yt;
    logic [15:0] yp;
  } prod_t;

endpackage

// ----- rtl/core/hsv_to_rgb_pixel_converter.sv -----
// Top level of the HSV to RGB pixel converter: six-stage pipeline.
//
// Converts one pixel per clock from hue (1/16 degree, taken modulo one turn),
// saturation, value and alpha into a packed word {alpha, blue, green, red}.
// A new pixel may enter on every cycle; the pipeline moves as one, so it holds
// only while a finished word sits on the output with color_stall high. The
// stages are: sector count from the hue, sector index and fraction, p/q/t
// numerators, scaling by value, reciprocal divide estimates, and the divide
// correction with channel pick and packing. Zero saturation falls out of the
// arithmetic as grey.
module hsv_to_rgb_pixel_converter import hsv2rgb_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        pix_valid,
  output logic        pix_stall,
  input  logic [15:0] hue,
  input  logic [7:0]  saturation,
  input  logic [7:0]  brightness_value,
  input  logic [7:0]  alpha,
  output logic        color_valid,
  input  logic        color_stall,
  output logic [31:0] color_word
);

  logic  advance;
  pix_t  pix;
  logic  sect_valid;
  sect_t sect;
  logic  prod_valid;
  prod_t prod;

  // Advance every stage unless the output word is held by the sink.
  assign advance   = !(color_valid && color_stall);
  assign pix_stall = !advance;

  assign pix.hue   = hue;
  assign pix.sat   = saturation;
  assign pix.val   = brightness_value;
  assign pix.alpha = alpha;

  hsv2rgb_sector u_sector (
    .clk       (clk),
    .rst       (rst),
    .en        (advance),
    .in_valid  (pix_valid),
    .pix       (pix),
    .out_valid (sect_valid),
    .sect      (sect)
  );

  hsv2rgb_terms u_terms (
    .clk       (clk),
    .rst       (rst),
    .en        (advance),
    .in_valid  (sect_valid),
    .sect      (sect),
    .out_valid (prod_valid),
    .prod      (prod)
  );

  hsv2rgb_scale u_scale (
    .clk        (clk),
    .rst        (rst),
    .en         (advance),
    .in_valid   (prod_valid),
    .prod       (prod),
    .out_valid  (color_valid),
    .color_word (color_word)
  );

endmodule

// ----- rtl/core/hsv2rgb_sector.sv -----
// Hue reduction: sector index and fraction within the sector (two stages).
module hsv2rgb_sector import hsv2rgb_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  en,
  input  logic  in_valid,
  input  pix_t  pix,
  output logic  out_valid,
  output sect_t sect
);

  logic        valid1;
  pix_t        pix1;
  logic [6:0]  turns1;
  logic [22:0] turns_prod;
  logic [12:0] six_prod;
  logic [3:0]  turn_div6;
  logic [6:0]  sector_wide;
  logic [16:0] sector_base;
  logic [16:0] frac_wide;

  // Stage 1: whole sectors in the hue.
  assign turns_prod = 23'(pix.hue[15:6]) * 23'(RECIP_15);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid1 <= 1'b0;
    end else if (en) begin
      valid1 <= in_valid;
    end
    if (en) begin
      pix1   <= pix;
      turns1 <= turns_prod[RECIP_15_SH +: 7];
    end
  end

  // Stage 2: fold whole sectors into one turn, keep the remainder.
  assign six_prod    = 13'(turns1) * 13'(RECIP_6);
  assign turn_div6   = six_prod[RECIP_6_SH +: 4];
  assign sector_wide = turns1 - ((7'(turn_div6) << 2) + (7'(turn_div6) << 1));
  assign sector_base = 17'(turns1) * 17'(HUE_SECTOR);
  assign frac_wide   = {1'b0, pix1.hue} - sector_base;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= valid1;
    end
    if (en) begin
      sect.sector <= sector_wide[2:0];
      sect.frac   <= frac_wide[9:0];
      sect.sat    <= pix1.sat;
      sect.val    <= pix1.val;
      sect.alpha  <= pix1.alpha;
    end
  end

endmodule

// ----- rtl/core/hsv2rgb_terms.sv -----
// Numerators of p, q and t, then their products with value (two stages).
module hsv2rgb_terms import hsv2rgb_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  en,
  input  logic  in_valid,
  input  sect_t sect,
  output logic  out_valid,
  output prod_t prod
);

  logic        valid3;
  logic [2:0]  sector3;
  logic [7:0]  val3;
  logic [7:0]  alpha3;
  logic [17:0] nq3;
  logic [17:0] nt3;
  logic [7:0]  np3;
  logic [17:0] sat_frac;
  logic [17:0] sat_rest;

  // Stage 3: numerators over the common denominator.
  assign sat_frac = 18'(sect.sat) * 18'(sect.frac);
  assign sat_rest = 18'(sect.sat) * (18'(HUE_SECTOR) - 18'(sect.frac));

  always_ff @(posedge clk) begin
    if (rst) begin
      valid3 <= 1'b0;
    end else if (en) begin
      valid3 <= in_valid;
    end
    if (en) begin
      sector3 <= sect.sector;
      val3    <= sect.val;
      alpha3  <= sect.alpha;
      nq3     <= 18'(FRAC_DEN) - sat_frac;
      nt3     <= 18'(FRAC_DEN) - sat_rest;
      np3     <= 8'd255 - sect.sat;
    end
  end

  // Stage 4: scale by value.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= valid3;
    end
    if (en) begin
      prod.sector <= sector3;
      prod.val    <= val3;
      prod.alpha  <= alpha3;
      prod.yq     <= 26'(val3) * 26'(nq3);
      prod.yt     <= 26'(val3) * 26'(nt3);
      prod.yp     <= 16'(val3) * 16'(np3);
    end
  end

endmodule

// ----- rtl/core/hsv2rgb_scale.sv -----
// Constant divides, channel selection by sector and packing (two stages).
module hsv2rgb_scale import hsv2rgb_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic        in_valid,
  input  prod_t       prod,
  output logic        out_valid,
  output logic [31:0] color_word
);

  logic        valid5;
  prod_t       prod5;
  logic [7:0]  qe5;
  logic [7:0]  te5;
  logic [7:0]  pe5;
  logic [40:0] q_est;
  logic [40:0] t_est;
  logic [24:0] p_est;
  logic [25:0] q_rem;
  logic [25:0] t_rem;
  logic [15:0] p_rem;
  logic [7:0]  q_ch;
  logic [7:0]  t_ch;
  logic [7:0]  p_ch;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;

  // Stage 5: reciprocal estimates, low by at most one.
  assign q_est = 41'(prod.yq) * 41'(RECIP_DEN);
  assign t_est = 41'(prod.yt) * 41'(RECIP_DEN);
  assign p_est = 25'(prod.yp) * 25'(RECIP_255);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid5 <= 1'b0;
    end else if (en) begin
      valid5 <= in_valid;
    end
    if (en) begin
      prod5 <= prod;
      qe5   <= q_est[RECIP_DEN_SH +: 8];
      te5   <= t_est[RECIP_DEN_SH +: 8];
      pe5   <= p_est[RECIP_255_SH +: 8];
    end
  end

  // Stage 6: bump each estimate when the remainder reaches the divisor.
  assign q_rem = prod5.yq - 26'(qe5) * 26'(FRAC_DEN);
  assign t_rem = prod5.yt - 26'(te5) * 26'(FRAC_DEN);
  assign p_rem = prod5.yp - 16'(pe5) * 16'd255;
  assign q_ch  = (q_rem >= 26'(FRAC_DEN)) ? qe5 + 8'd1 : qe5;
  assign t_ch  = (t_rem >= 26'(FRAC_DEN)) ? te5 + 8'd1 : te5;
  assign p_ch  = (p_rem >= 16'd255) ? pe5 + 8'd1 : pe5;

  always_comb begin
    unique case (prod5.sector)
      SECTOR_RED_YEL: begin
        red = prod5.val; green = t_ch; blue = p_ch;
      end
      SECTOR_YEL_GRN: begin
        red = q_ch; green = prod5.val; blue = p_ch;
      end
      SECTOR_GRN_CYN: begin
        red = p_ch; green = prod5.val; blue = t_ch;
      end
      SECTOR_CYN_BLU: begin
        red = p_ch; green = q_ch; blue = prod5.val;
      end
      SECTOR_BLU_MAG: begin
        red = t_ch; green = p_ch; blue = prod5.val;
      end
      default: begin
        red = prod5.val; green = p_ch; blue = q_ch;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= valid5;
    end
    if (en) begin
      color_word <= {prod5.alpha, blue, green, red};
    end
  end

endmodule

// ----- tb/hsv_to_rgb_pixel_converter_checker.sv -----
// Checker for the HSV to RGB converter: predicts each color word and compares it on transfer.
`timescale 1ns / 1ps

module hsv_to_rgb_pixel_converter_checker import hsv2rgb_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        pix_valid,
  input  logic        pix_stall,
  input  logic [15:0] hue,
  input  logic [7:0]  saturation,
  input  logic [7:0]  brightness_value,
  input  logic [7:0]  alpha,
  input  logic        color_valid,
  input  logic        color_stall,
  input  logic [31:0] color_word,
  output int          fail_count,
  output int          outstanding
);

  localparam int unsigned HUE_TURN = 6 * HUE_SECTOR;

  logic [31:0] color_q[$];
  logic [31:0] want_word;
  int          errors = 0;

  assign fail_count = errors;

  task automatic report_mismatch(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    errors++;
  endtask

  // Exact integer form of the HSV sector formula; grey falls out when saturation is zero.
  function automatic logic [31:0] hsv_color(input logic [15:0] h, input logic [7:0] s,
                                            input logic [7:0] v, input logic [7:0] a);
    int unsigned turn_pos, f, p, q, t;
    logic [2:0]  sector;
    logic [7:0]  r, g, b;
    turn_pos = h % HUE_TURN;
    sector   = 3'(turn_pos / HUE_SECTOR);
    f        = turn_pos % HUE_SECTOR;
    p = (v * (255 - s)) / 255;
    q = (v * (FRAC_DEN - s * f)) / FRAC_DEN;
    t = (v * (FRAC_DEN - s * (HUE_SECTOR - f))) / FRAC_DEN;
    case (sector)
      SECTOR_RED_YEL: begin r = v;     g = t[7:0]; b = p[7:0]; end
      SECTOR_YEL_GRN: begin r = q[7:0]; g = v;     b = p[7:0]; end
      SECTOR_GRN_CYN: begin r = p[7:0]; g = v;     b = t[7:0]; end
      SECTOR_CYN_BLU: begin r = p[7:0]; g = q[7:0]; b = v;     end
      SECTOR_BLU_MAG: begin r = t[7:0]; g = p[7:0]; b = v;     end
      default:        begin r = v;     g = p[7:0]; b = q[7:0]; end
    endcase
    return {a, b, g, r};
  endfunction

  always @(posedge clk) begin
    if (!rst) begin
      // Retire the output side first so a stray word is never matched to a pixel
      // entering on the same edge.
      if (color_valid && !color_stall) begin
        if (color_q.size() == 0) begin
          report_mismatch($sformatf("color word %h with no pixel pending", color_word));
        end else begin
          want_word = color_q.pop_front();
          if (color_word !== want_word)
            report_mismatch($sformatf("color word %h, want %h (a/b/g/r)",
                                      color_word, want_word));
        end
      end
      if (pix_valid && !pix_stall)
        color_q.push_back(hsv_color(hue, saturation, brightness_value, alpha));
    end
    outstanding <= color_q.size();
  end

endmodule

// ----- tb/hsv_to_rgb_pixel_converter_tb.sv -----
// Testbench top for the HSV to RGB converter: drives pixels and output stall, gives the verdict.
`timescale 1ns / 1ps

module hsv_to_rgb_pixel_converter_tb;

  // Six pipeline stages; drain the pipeline before the verdict.
  localparam int DRAIN_CYCLES = 24;
  // Run limit, sized for the slowest legal run (long gaps plus long stalls per pixel).
  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_PIXELS = 650;
  localparam int HOLD_OFF_CYCLES = 150;

  logic        clk = 1'b0;
  logic        rst;
  logic        pix_valid;
  logic        pix_stall;
  logic [15:0] hue;
  logic [7:0]  saturation;
  logic [7:0]  brightness_value;
  logic [7:0]  alpha;
  logic        color_valid;
  logic        color_stall;
  logic [31:0] color_word;

  int fail_count;
  int outstanding;
  int cycle_cnt = 0;

  // Handshake between the sender and the receiver for the one long output hold-off.
  logic hold_off_req  = 1'b0;
  logic hold_off_done = 1'b0;

  always #10 clk = ~clk;

  hsv_to_rgb_pixel_converter u_dut (
    .clk              (clk),
    .rst              (rst),
    .pix_valid        (pix_valid),
    .pix_stall        (pix_stall),
    .hue              (hue),
    .saturation       (saturation),
    .brightness_value (brightness_value),
    .alpha            (alpha),
    .color_valid      (color_valid),
    .color_stall      (color_stall),
    .color_word       (color_word)
  );

  hsv_to_rgb_pixel_converter_checker u_checker (
    .clk              (clk),
    .rst              (rst),
    .pix_valid        (pix_valid),
    .pix_stall        (pix_stall),
    .hue              (hue),
    .saturation       (saturation),
    .brightness_value (brightness_value),
    .alpha            (alpha),
    .color_valid      (color_valid),
    .color_stall      (color_stall),
    .color_word       (color_word),
    .fail_count       (fail_count),
    .outstanding      (outstanding)
  );

  // Hold valid low for a random gap: mostly none, sometimes short, rarely long.
  task automatic pixel_gap();
    int roll, len;
    roll = $urandom_range(0, 99);
    if (roll < 55)      len = 0;
    else if (roll < 90) len = $urandom_range(1, 3);
    else                len = $urandom_range(8, 30);
    if (len > 0) begin
      pix_valid <= 1'b0;
      repeat (len) @(posedge clk);
    end
  endtask

  // Offer one pixel and advance only once it transfers. Valid stays high into the
  // next pixel unless a gap follows, so it is never dropped and raised in one step.
  task automatic send_pixel(input logic [15:0] h, input logic [7:0] s,
                            input logic [7:0] v, input logic [7:0] a);
    pix_valid        <= 1'b1;
    hue              <= h;
    saturation       <= s;
    brightness_value <= v;
    alpha            <= a;
    do @(posedge clk); while (pix_stall);
  endtask

  // Wait until every predicted color word has come back. The first edge lets the
  // checker's count catch up with the pixel that just transferred.
  task automatic wait_all_colors();
    pix_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // Hue skewed toward sector edges and the wrap, with full 16-bit values mixed in.
  function automatic logic [15:0] pick_hue();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 50)
      return 16'($urandom_range(0, 5759));
    else if (roll < 75)
      return 16'($urandom_range(0, 5) * 960 + $urandom_range(0, 2) * 479 +
                 $urandom_range(0, 1));
    else
      return 16'($urandom());
  endfunction

  function automatic logic [7:0] pick_byte();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 8)       return 8'h00;
    else if (roll < 16) return 8'hff;
    else                return 8'($urandom());
  endfunction

  // Receiver: alternate free-running stretches with short and long stalls, and take
  // the one long hold-off when the sender asks for it.
  initial begin
    int roll, len;
    color_stall <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_off_req && !hold_off_done) begin
        color_stall <= 1'b1;
        for (int n = 0; n < HOLD_OFF_CYCLES; n++) @(posedge clk);
        hold_off_done = 1'b1;
      end else begin
        roll = $urandom_range(0, 99);
        if (roll < 45) begin
          color_stall <= 1'b0;
          len = $urandom_range(1, 30);
        end else if (roll < 90) begin
          color_stall <= 1'b1;
          len = $urandom_range(1, 3);
        end else begin
          color_stall <= 1'b1;
          len = $urandom_range(10, 40);
        end
        repeat (len) @(posedge clk);
      end
    end
  end

  // Watchdog: end the run if the pipeline never drains.
  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    rst              <= 1'b1;
    pix_valid        <= 1'b0;
    hue              <= '0;
    saturation       <= '0;
    brightness_value <= '0;
    alpha            <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: every sector start, the first and last sector ends, the wrap at one
    // turn and beyond, grey from zero saturation, black from zero value, and byte extremes.
    send_pixel(16'd0,     8'd255, 8'd255, 8'd255);
    send_pixel(16'd959,   8'd255, 8'd255, 8'd0);
    send_pixel(16'd960,   8'd255, 8'd255, 8'd255);
    send_pixel(16'd1920,  8'd200, 8'd180, 8'd17);
    send_pixel(16'd2400,  8'd255, 8'd255, 8'd128);
    send_pixel(16'd2880,  8'd255, 8'd255, 8'd1);
    send_pixel(16'd3840,  8'd128, 8'd200, 8'd2);
    send_pixel(16'd4320,  8'd254, 8'd1,   8'd3);
    send_pixel(16'd4800,  8'd255, 8'd255, 8'd4);
    send_pixel(16'd5279,  8'd77,  8'd255, 8'd200);
    send_pixel(16'd5759,  8'd255, 8'd255, 8'd5);
    send_pixel(16'd5760,  8'd255, 8'd255, 8'd6);
    send_pixel(16'd5761,  8'd100, 8'd100, 8'd7);
    send_pixel(16'd12000, 8'd255, 8'd240, 8'd8);
    send_pixel(16'd65535, 8'd255, 8'd255, 8'd255);
    send_pixel(16'd3000,  8'd0,   8'd200, 8'd9);
    send_pixel(16'd0,     8'd0,   8'd255, 8'd10);
    send_pixel(16'd65535, 8'd0,   8'd0,   8'd0);
    send_pixel(16'd1234,  8'd255, 8'd0,   8'd11);
    send_pixel(16'd480,   8'd1,   8'd255, 8'd12);
    send_pixel(16'd32768, 8'd170, 8'd85,  8'd170);
    wait_all_colors();

    for (int i = 0; i < RANDOM_PIXELS; i++) begin
      // Every third block of 40 pixels runs back to back with no sender gaps.
      if ((i / 40) % 3 != 1) pixel_gap();
      if (i == 200) hold_off_req = 1'b1;
      // Pause the sender once until the pipeline is empty.
      if (i == 420) wait_all_colors();
      send_pixel(pick_hue(), pick_byte(), pick_byte(), 8'($urandom()));
    end

    wait_all_colors();
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
    if (fail_count == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/hsv2rgb_pkg.sv
rtl/core/hsv2rgb_sector.sv
rtl/core/hsv2rgb_terms.sv
rtl/core/hsv2rgb_scale.sv
rtl/core/hsv_to_rgb_pixel_converter.sv
tb/hsv_to_rgb_pixel_converter_checker.sv
tb/hsv_to_rgb_pixel_converter_tb.sv
